/* hdl/clcd_pkg.sv */
// Shared types, constants and helper functions for the character LCD bus sequencer.
`timescale 1ns / 1ps
`default_nettype none

package clcd_pkg;

    // Default width of the phase tick counter
    localparam int COUNT_BITS_DEF = 24;

    // Timing registers
    localparam int REG_W     = 24;
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_BOOT        = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_KNOCK  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_KNOCK = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SETUP       = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE       = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD        = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVER     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_PULSE  = 4'd7;

    localparam logic [REG_W-1:0] RST_BOOT        = 24'd300000;
    localparam logic [REG_W-1:0] RST_LONG_KNOCK  = 24'd82000;
    localparam logic [REG_W-1:0] RST_SHORT_KNOCK = 24'd2;
    localparam logic [REG_W-1:0] RST_SETUP       = 24'd2800;
    localparam logic [REG_W-1:0] RST_PULSE       = 24'd9000;
    localparam logic [REG_W-1:0] RST_HOLD        = 24'd200;
    localparam logic [REG_W-1:0] RST_RECOVER     = 24'd9000;
    localparam logic [REG_W-1:0] RST_POLL_PULSE  = 24'd6400;

    // Request modes
    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_INSTR = 3'd1;
    localparam logic [2:0] MODE_DATA  = 3'd2;
    localparam logic [2:0] MODE_POS   = 3'd3;
    localparam logic [2:0] MODE_INIT  = 3'd4;

    // Bus constants
    localparam logic [7:0] KNOCK_BYTE   = 8'h30;
    localparam logic [7:0] SET_DDRAM    = 8'h80;
    localparam logic [6:0] ROW_ODD_BASE = 7'h40;
    localparam logic [6:0] ROW_HI_BASE  = 7'h14;
    localparam logic [7:0] LINE_LEN     = 8'd20;
    localparam int         BUSY_BIT     = 7;

    // Init sequence steps
    localparam logic [3:0] STEP_FIRST_BYTE = 4'd3;
    localparam logic [3:0] STEP_LAST_BYTE  = 4'd8;

    // Timing register file contents
    typedef struct packed {
        logic [REG_W-1:0] boot;
        logic [REG_W-1:0] long_knock;
        logic [REG_W-1:0] short_knock;
        logic [REG_W-1:0] setup;
        logic [REG_W-1:0] pulse;
        logic [REG_W-1:0] hold;
        logic [REG_W-1:0] recover;
        logic [REG_W-1:0] poll_pulse;
    } cfg_t;

    // One input item
    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] value;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] bus_in;
    } req_t;

    // One result item
    typedef struct packed {
        logic       lcd_enable;
        logic       lcd_rs;
        logic       lcd_rw;
        logic [7:0] bus_out;
        logic       bus_drive;
        logic       ready_res;
        logic       rejected;
    } res_t;

    // Output queue status towards the top level
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Sequencer phases, one-hot
    typedef enum logic [10:0] {
        PH_IDLE       = 11'b000_0000_0001,
        PH_BOOT       = 11'b000_0000_0010,
        PH_KNOCK      = 11'b000_0000_0100,
        PH_KGAP       = 11'b000_0000_1000,
        PH_PPULSE     = 11'b000_0001_0000,
        PH_PHOLD_BUSY = 11'b000_0010_0000,
        PH_PHOLD_FREE = 11'b000_0100_0000,
        PH_SETUP      = 11'b000_1000_0000,
        PH_PULSE      = 11'b001_0000_0000,
        PH_HOLD       = 11'b010_0000_0000,
        PH_RECOVER    = 11'b100_0000_0000
    } phase_t;

    // Instruction byte sent at a given init step
    function automatic logic [7:0] init_byte(input logic [3:0] step);
        logic [7:0] b;
        case (step)
            4'd3:    b = 8'h38;
            4'd4:    b = 8'h08;
            4'd5:    b = 8'h01;
            4'd6:    b = 8'h06;
            4'd7:    b = 8'h0F;
            4'd8:    b = 8'h80;
            default: b = 8'h38;
        endcase
        return b;
    endfunction

    // Column modulo 20 by reciprocal multiply (205 / 4096), exact for 8-bit input
    function automatic logic [4:0] col_mod20(input logic [7:0] col);
        logic [15:0] prod;
        logic [3:0]  quot;
        logic [7:0]  back;
        logic [7:0]  rem;
        prod = 16'(col) * 16'd205;
        quot = prod[15:12];
        back = 8'(8'(quot) * LINE_LEN);
        rem  = col - back;
        return rem[4:0];
    endfunction

    // DDRAM address command for a row and column on a 4x20 panel
    function automatic logic [7:0] pos_byte(input logic [7:0] col, input logic [7:0] row);
        logic [6:0] base;
        logic [6:0] addr;
        base = (row[0] ? ROW_ODD_BASE : 7'h00) + (row[1] ? ROW_HI_BASE : 7'h00);
        addr = base + 7'(col_mod20(col));
        return SET_DDRAM | {1'b0, addr};
    endfunction

endpackage

`default_nettype wire

/* hdl/clcd_ifs.sv */
// Handshake interfaces for request, result and configuration channels.
`timescale 1ns / 1ps
`default_nettype none

interface clcd_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [7:0] value;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] bus_in;

    modport source (output valid, mode, value, col, row, bus_in, input ready);
    modport sink   (input valid, mode, value, col, row, bus_in, output ready);
endinterface

interface clcd_res_if;
    logic       valid;
    logic       ready;
    logic       lcd_enable;
    logic       lcd_rs;
    logic       lcd_rw;
    logic [7:0] bus_out;
    logic       bus_drive;
    logic       ready_res;
    logic       rejected;

    modport source (output valid, lcd_enable, lcd_rs, lcd_rw, bus_out, bus_drive,
                    ready_res, rejected, input ready);
    modport sink   (input valid, lcd_enable, lcd_rs, lcd_rw, bus_out, bus_drive,
                    ready_res, rejected, output ready);
endinterface

interface clcd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [clcd_pkg::CFG_IDX_W-1:0] index;
    logic [clcd_pkg::REG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hdl/clcd_cfg_regs.sv */
// Timing register file written through the configuration channel.
`timescale 1ns / 1ps
`default_nettype none

module clcd_cfg_regs (
    input  wire logic      clk,
    input  wire logic      rst_n,
    clcd_cfg_if.sink       cfg,
    output clcd_pkg::cfg_t regs
);

    clcd_pkg::cfg_t regs_reg;
    clcd_pkg::cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // Register write decode; indexes beyond the list are dropped
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                clcd_pkg::REG_BOOT:        regs_next.boot        = cfg.data;
                clcd_pkg::REG_LONG_KNOCK:  regs_next.long_knock  = cfg.data;
                clcd_pkg::REG_SHORT_KNOCK: regs_next.short_knock = cfg.data;
                clcd_pkg::REG_SETUP:       regs_next.setup       = cfg.data;
                clcd_pkg::REG_PULSE:       regs_next.pulse       = cfg.data;
                clcd_pkg::REG_HOLD:        regs_next.hold        = cfg.data;
                clcd_pkg::REG_RECOVER:     regs_next.recover     = cfg.data;
                clcd_pkg::REG_POLL_PULSE:  regs_next.poll_pulse  = cfg.data;
                default:                   regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.boot        <= clcd_pkg::RST_BOOT;
            regs_reg.long_knock  <= clcd_pkg::RST_LONG_KNOCK;
            regs_reg.short_knock <= clcd_pkg::RST_SHORT_KNOCK;
            regs_reg.setup       <= clcd_pkg::RST_SETUP;
            regs_reg.pulse       <= clcd_pkg::RST_PULSE;
            regs_reg.hold        <= clcd_pkg::RST_HOLD;
            regs_reg.recover     <= clcd_pkg::RST_RECOVER;
            regs_reg.poll_pulse  <= clcd_pkg::RST_POLL_PULSE;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/clcd_core.sv */
// Phase sequencer: one tick per item, computes pin levels for the item.
`timescale 1ns / 1ps
`default_nettype none

module clcd_core #(
    parameter int COUNT_BITS = clcd_pkg::COUNT_BITS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           fire,
    input  wire clcd_pkg::req_t req,
    input  wire clcd_pkg::cfg_t regs,
    output clcd_pkg::res_t      res
);

    localparam int CMP_W = (COUNT_BITS > clcd_pkg::REG_W) ? COUNT_BITS : clcd_pkg::REG_W;
    localparam logic [CMP_W-1:0] CNT_MAX = CMP_W'({COUNT_BITS{1'b1}});

    clcd_pkg::phase_t       phase_reg,    phase_next;
    logic [COUNT_BITS-1:0]  tick_reg,     tick_next;
    logic [7:0]             pbyte_reg,    pbyte_next;
    logic                   prs_reg,      prs_next;
    logic [3:0]             step_reg,     step_next;
    logic                   init_reg,     init_next;

    logic [COUNT_BITS-1:0]  tick_inc;
    logic [clcd_pkg::REG_W-1:0] dur_raw;
    logic [CMP_W-1:0]       dur_clamp;
    logic [CMP_W-1:0]       dur;
    logic                   is_req;
    logic                   rejected;

    assign is_req   = (req.mode == clcd_pkg::MODE_INSTR) || (req.mode == clcd_pkg::MODE_DATA)
                   || (req.mode == clcd_pkg::MODE_POS)   || (req.mode == clcd_pkg::MODE_INIT);
    assign tick_inc = tick_reg + COUNT_BITS'(1);

    // Duration of the current phase, clamped to counter range and at least one tick
    always_comb
    begin
        unique case (phase_reg)
            clcd_pkg::PH_BOOT:       dur_raw = regs.boot;
            clcd_pkg::PH_KNOCK:      dur_raw = (step_reg == 4'd0) ? regs.long_knock :
                                               (step_reg == 4'd1) ? regs.short_knock :
                                                                    regs.pulse;
            clcd_pkg::PH_PPULSE:     dur_raw = regs.poll_pulse;
            clcd_pkg::PH_PHOLD_BUSY,
            clcd_pkg::PH_PHOLD_FREE: dur_raw = regs.hold;
            clcd_pkg::PH_SETUP:      dur_raw = regs.setup;
            clcd_pkg::PH_PULSE:      dur_raw = regs.pulse;
            clcd_pkg::PH_HOLD:       dur_raw = regs.hold;
            clcd_pkg::PH_RECOVER:    dur_raw = regs.recover;
            default:                 dur_raw = clcd_pkg::REG_W'(1);
        endcase
        dur_clamp = (CMP_W'(dur_raw) > CNT_MAX) ? CNT_MAX : CMP_W'(dur_raw);
        dur       = (dur_clamp == '0) ? CMP_W'(1) : dur_clamp;
    end

    // Next state for one tick
    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        pbyte_next = pbyte_reg;
        prs_next   = prs_reg;
        step_next  = step_reg;
        init_next  = init_reg;
        rejected   = 1'b0;

        if (phase_reg != clcd_pkg::PH_IDLE)
        begin
            rejected  = is_req;
            tick_next = tick_inc;
            if (CMP_W'(tick_inc) >= dur)
            begin
                tick_next = '0;
                unique case (phase_reg)
                    clcd_pkg::PH_BOOT:
                    begin
                        step_next  = 4'd0;
                        phase_next = clcd_pkg::PH_KNOCK;
                    end
                    clcd_pkg::PH_KNOCK:      phase_next = clcd_pkg::PH_KGAP;
                    clcd_pkg::PH_KGAP:
                    begin
                        if (step_reg < 4'd2)
                        begin
                            step_next  = step_reg + 4'd1;
                            phase_next = clcd_pkg::PH_KNOCK;
                        end
                        else
                        begin
                            step_next  = clcd_pkg::STEP_FIRST_BYTE;
                            pbyte_next = clcd_pkg::init_byte(clcd_pkg::STEP_FIRST_BYTE);
                            prs_next   = 1'b0;
                            phase_next = clcd_pkg::PH_PPULSE;
                        end
                    end
                    clcd_pkg::PH_PPULSE:
                        phase_next = req.bus_in[clcd_pkg::BUSY_BIT] ? clcd_pkg::PH_PHOLD_BUSY
                                                                    : clcd_pkg::PH_PHOLD_FREE;
                    clcd_pkg::PH_PHOLD_BUSY: phase_next = clcd_pkg::PH_PPULSE;
                    clcd_pkg::PH_PHOLD_FREE: phase_next = clcd_pkg::PH_SETUP;
                    clcd_pkg::PH_SETUP:      phase_next = clcd_pkg::PH_PULSE;
                    clcd_pkg::PH_PULSE:      phase_next = clcd_pkg::PH_HOLD;
                    clcd_pkg::PH_HOLD:       phase_next = clcd_pkg::PH_RECOVER;
                    clcd_pkg::PH_RECOVER:
                    begin
                        if (!init_reg && step_reg >= clcd_pkg::STEP_FIRST_BYTE
                            && step_reg < clcd_pkg::STEP_LAST_BYTE)
                        begin
                            step_next  = step_reg + 4'd1;
                            pbyte_next = clcd_pkg::init_byte(step_reg + 4'd1);
                            prs_next   = 1'b0;
                            phase_next = clcd_pkg::PH_PPULSE;
                        end
                        else
                        begin
                            init_next  = 1'b1;
                            step_next  = 4'd0;
                            phase_next = clcd_pkg::PH_IDLE;
                        end
                    end
                    default:                 phase_next = clcd_pkg::PH_IDLE;
                endcase
            end
        end
        else if (is_req)
        begin
            tick_next = '0;
            if (req.mode == clcd_pkg::MODE_INIT)
            begin
                init_next  = 1'b0;
                step_next  = 4'd0;
                phase_next = clcd_pkg::PH_BOOT;
            end
            else if (!init_reg)
            begin
                rejected = 1'b1;
            end
            else
            begin
                phase_next = clcd_pkg::PH_PPULSE;
                prs_next   = (req.mode == clcd_pkg::MODE_DATA);
                pbyte_next = (req.mode == clcd_pkg::MODE_POS) ?
                             clcd_pkg::pos_byte(req.col, req.row) : req.value;
            end
        end
    end

    // Pin levels for the phase entered by this item
    always_comb
    begin
        res            = '0;
        res.rejected   = rejected;
        res.ready_res  = (phase_next == clcd_pkg::PH_IDLE);
        unique case (phase_next)
            clcd_pkg::PH_BOOT:       res.bus_drive = 1'b1;
            clcd_pkg::PH_KNOCK:
            begin
                res.lcd_enable = 1'b1;
                res.bus_out    = clcd_pkg::KNOCK_BYTE;
                res.bus_drive  = 1'b1;
            end
            clcd_pkg::PH_KGAP:
            begin
                res.bus_out   = clcd_pkg::KNOCK_BYTE;
                res.bus_drive = 1'b1;
            end
            clcd_pkg::PH_PPULSE:
            begin
                res.lcd_enable = 1'b1;
                res.lcd_rw     = 1'b1;
            end
            clcd_pkg::PH_PHOLD_BUSY,
            clcd_pkg::PH_PHOLD_FREE: res.lcd_rw = 1'b1;
            clcd_pkg::PH_SETUP,
            clcd_pkg::PH_HOLD:
            begin
                res.lcd_rs    = prs_next;
                res.bus_out   = pbyte_next;
                res.bus_drive = 1'b1;
            end
            clcd_pkg::PH_PULSE:
            begin
                res.lcd_enable = 1'b1;
                res.lcd_rs     = prs_next;
                res.bus_out    = pbyte_next;
                res.bus_drive  = 1'b1;
            end
            clcd_pkg::PH_RECOVER:
            begin
                res.lcd_rs    = prs_next;
                res.bus_drive = 1'b1;
            end
            default:                 res.bus_drive = 1'b0;
        endcase
    end

    // State registers advance once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= clcd_pkg::PH_IDLE;
            tick_reg  <= '0;
            pbyte_reg <= '0;
            prs_reg   <= 1'b0;
            step_reg  <= '0;
            init_reg  <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            pbyte_reg <= pbyte_next;
            prs_reg   <= prs_next;
            step_reg  <= step_next;
            init_reg  <= init_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/clcd_out_queue.sv */
// Two-entry result queue that decouples the result channel from the input side.
`timescale 1ns / 1ps
`default_nettype none

module clcd_out_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire clcd_pkg::res_t   push_data,
    output clcd_pkg::queue_status_t status,
    clcd_res_if.source            res
);

    clcd_pkg::res_t entry_reg [2];
    logic           head_reg,  head_next;
    logic           tail_reg,  tail_next;
    logic [1:0]     count_reg, count_next;
    logic           pop;
    clcd_pkg::res_t head_data;

    assign pop          = res.valid && res.ready;
    assign status       = '{full: (count_reg == 2'd2), empty: (count_reg == 2'd0)};
    assign head_data    = entry_reg[head_reg];

    // Result channel driven from the head entry
    assign res.valid      = !status.empty;
    assign res.lcd_enable = head_data.lcd_enable;
    assign res.lcd_rs     = head_data.lcd_rs;
    assign res.lcd_rw     = head_data.lcd_rw;
    assign res.bus_out    = head_data.bus_out;
    assign res.bus_drive  = head_data.bus_drive;
    assign res.ready_res  = head_data.ready_res;
    assign res.rejected   = head_data.rejected;

    // Pointer and fill bookkeeping
    always_comb
    begin
        head_next  = pop  ? !head_reg : head_reg;
        tail_next  = push ? !tail_reg : tail_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            tail_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[tail_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* hdl/char_lcd_bus_sequencer_unit.sv */
// Top level of the character LCD bus sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Pin-timing sequencer for an 8-bit HD44780-style character LCD bus. Every
// request item is one clock tick of the panel timing and yields exactly one
// result item with the E, RS, RW, data and drive levels after that tick, plus
// idle and reject flags. Items are taken one per cycle while the result queue
// has room: an item sits in the input register, the sequencer state (phase,
// tick counter of 24 bits by default and its compare against the selected
// timing register) updates as the item leaves that register, and the result
// goes to a two-entry queue, from which it is offered on the result channel.
// The combinational counter increment and compare sets the clock rate. The
// user must write the timing registers through the configuration channel only
// while no item is in flight; the block itself does not enforce this.
module char_lcd_bus_sequencer_unit #(
    parameter int COUNT_BITS = clcd_pkg::COUNT_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    clcd_req_if.sink   req,
    clcd_res_if.source res,
    clcd_cfg_if.sink   cfg
);

    logic                    s1_valid_reg, s1_valid_next;
    clcd_pkg::req_t          s1_req_reg;
    clcd_pkg::req_t          req_in;
    logic                    fire;
    logic                    in_take;
    clcd_pkg::cfg_t          regs;
    clcd_pkg::res_t          core_res;
    clcd_pkg::queue_status_t q_status;

    assign req_in = '{mode: req.mode, value: req.value, col: req.col,
                      row: req.row, bus_in: req.bus_in};

    // Input register: one item moves on when the queue has room
    assign fire      = s1_valid_reg && !q_status.full;
    assign req.ready = !s1_valid_reg || fire;
    assign in_take   = req.valid && req.ready;

    always_comb
    begin
        s1_valid_next = in_take ? 1'b1 : (fire ? 1'b0 : s1_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_req_reg <= req_in;
        end
    end

    clcd_cfg_regs u_cfg_regs (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg),
        .regs (regs)
    );

    clcd_core #(
        .COUNT_BITS(COUNT_BITS)
    ) u_core (
        .clk  (clk),
        .rst_n(rst_n),
        .fire (fire),
        .req  (s1_req_reg),
        .regs (regs),
        .res  (core_res)
    );

    clcd_out_queue u_out_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fire),
        .push_data(core_res),
        .status   (q_status),
        .res      (res)
    );

    // Bus is released to zero whenever it is not driven
    a_bus_zero_undriven: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.bus_drive |-> res.bus_out == 8'h00)
        else $error("bus_out nonzero while not driving");

    // Busy-flag read never drives the data pins
    a_read_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.lcd_rw |-> !res.bus_drive && !res.lcd_rs)
        else $error("bus driven during busy read");

    // Idle result has all pins quiet
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.ready_res |-> !res.lcd_enable && !res.bus_drive && !res.lcd_rw)
        else $error("pins active while idle");

    // An item held in the input register reaches the queue in the next cycle unless full
    a_fire_push: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !(res.valid && res.ready) |=> !q_status.empty)
        else $error("result lost between core and queue");

endmodule

`default_nettype wire

/* tb/sv/clcd_pin_checker.sv */
// Checker for the LCD bus sequencer: predicts the pin levels of every item and compares results.
`timescale 1ns / 1ps

module clcd_pin_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    clcd_req_if       req,
    clcd_res_if       res,
    clcd_cfg_if       cfg,
    output int        fail_count,
    output int        pending,
    output logic      seq_idle
);
    import clcd_pkg::*;

    // Instruction bytes sent after the three knocks
    localparam logic [7:0] INIT_SEQ [6] = '{8'h38, 8'h08, 8'h01, 8'h06, 8'h0F, 8'h80};
    // Knocks are counted 0..2 in the step counter
    localparam logic [3:0] LAST_KNOCK = 4'd2;

    // Predicted sequencer state
    logic [REG_W-1:0] timing [NUM_REGS];
    phase_t           ph;
    logic [REG_W-1:0] cnt;        // counter is as wide as the timing registers
    logic [7:0]       pend_byte;
    logic             pend_rs;
    logic [3:0]       step;
    logic             initd;

    res_t pin_levels_q [$];
    int   errs;

    // Length of the current phase, at least one tick
    function automatic logic [REG_W-1:0] phase_len();
        logic [REG_W-1:0] d;
        case (ph)
            PH_BOOT:       d = timing[REG_BOOT];
            PH_KNOCK:      d = (step == 4'd0) ? timing[REG_LONG_KNOCK] :
                               (step == 4'd1) ? timing[REG_SHORT_KNOCK] : timing[REG_PULSE];
            PH_PPULSE:     d = timing[REG_POLL_PULSE];
            PH_PHOLD_BUSY,
            PH_PHOLD_FREE: d = timing[REG_HOLD];
            PH_SETUP:      d = timing[REG_SETUP];
            PH_PULSE:      d = timing[REG_PULSE];
            PH_HOLD:       d = timing[REG_HOLD];
            PH_RECOVER:    d = timing[REG_RECOVER];
            default:       d = 1;
        endcase
        if (d == 0)
            d = 1;
        return d;
    endfunction

    // Latch a byte and start with a busy poll
    task automatic load_transfer(input logic [7:0] b, input logic rs);
        pend_byte = b;
        pend_rs   = rs;
        ph        = PH_PPULSE;
    endtask

    // Move on once the current phase has run its length
    task automatic advance_phase(input logic [7:0] bus_in);
        cnt = '0;
        case (ph)
            PH_BOOT:
            begin
                step = '0;
                ph   = PH_KNOCK;
            end
            PH_KNOCK: ph = PH_KGAP;
            PH_KGAP:
                if (step < LAST_KNOCK)
                begin
                    step++;
                    ph = PH_KNOCK;
                end
                else
                begin
                    step = STEP_FIRST_BYTE;
                    load_transfer(INIT_SEQ[0], 1'b0);
                end
            PH_PPULSE:     ph = bus_in[BUSY_BIT] ? PH_PHOLD_BUSY : PH_PHOLD_FREE;
            PH_PHOLD_BUSY: ph = PH_PPULSE;
            PH_PHOLD_FREE: ph = PH_SETUP;
            PH_SETUP:      ph = PH_PULSE;
            PH_PULSE:      ph = PH_HOLD;
            PH_HOLD:       ph = PH_RECOVER;
            PH_RECOVER:
                if (!initd && step >= STEP_FIRST_BYTE && step < STEP_LAST_BYTE)
                begin
                    step++;
                    load_transfer(INIT_SEQ[step - STEP_FIRST_BYTE], 1'b0);
                end
                else
                begin
                    initd = 1'b1;
                    step  = '0;
                    ph    = PH_IDLE;
                end
            default: ph = PH_IDLE;
        endcase
    endtask

    // One tick of the sequencer: new state and the pin levels after it
    task automatic tick_sequencer(input logic [2:0] mode, input logic [7:0] value,
                                  input logic [7:0] col, input logic [7:0] row,
                                  input logic [7:0] bus_in, output res_t r);
        logic       asking;
        logic       rej;
        logic [6:0] addr;
        asking = (mode >= MODE_INSTR) && (mode <= MODE_INIT);
        rej    = 1'b0;
        if (ph != PH_IDLE)
        begin
            // busy: any request is dropped, the timer runs
            rej = asking;
            cnt = cnt + 1'b1;
            if (cnt >= phase_len())
                advance_phase(bus_in);
        end
        else if (asking)
        begin
            cnt = '0;
            if (mode == MODE_INIT)
            begin
                initd = 1'b0;
                step  = '0;
                ph    = PH_BOOT;
            end
            else if (!initd)
                rej = 1'b1;
            else if (mode == MODE_INSTR)
                load_transfer(value, 1'b0);
            else if (mode == MODE_DATA)
                load_transfer(value, 1'b1);
            else
            begin
                // 4x20 panel: rows 1 and 3 at +0x40, rows 2 and 3 at +0x14
                addr = (row[0] ? ROW_ODD_BASE : 7'h00) + (row[1] ? ROW_HI_BASE : 7'h00)
                     + 7'(col % LINE_LEN);
                load_transfer(SET_DDRAM | {1'b0, addr}, 1'b0);
            end
        end

        r           = '0;
        r.ready_res = (ph == PH_IDLE);
        r.rejected  = rej;
        case (ph)
            PH_BOOT:   r.bus_drive = 1'b1;
            PH_KNOCK:
            begin
                r.lcd_enable = 1'b1;
                r.bus_out    = KNOCK_BYTE;
                r.bus_drive  = 1'b1;
            end
            PH_KGAP:
            begin
                r.bus_out   = KNOCK_BYTE;
                r.bus_drive = 1'b1;
            end
            PH_PPULSE:
            begin
                r.lcd_enable = 1'b1;
                r.lcd_rw     = 1'b1;
            end
            PH_PHOLD_BUSY, PH_PHOLD_FREE: r.lcd_rw = 1'b1;
            PH_SETUP, PH_HOLD, PH_PULSE:
            begin
                r.lcd_enable = (ph == PH_PULSE);
                r.lcd_rs     = pend_rs;
                r.bus_out    = pend_byte;
                r.bus_drive  = 1'b1;
            end
            PH_RECOVER:
            begin
                r.lcd_rs    = pend_rs;
                r.bus_drive = 1'b1;
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0d ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errs++;
        end
    endtask

    // Track configuration, predict accepted items, compare results
    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        res_t got;
        if (!rst_n)
        begin
            timing[REG_BOOT]        = RST_BOOT;
            timing[REG_LONG_KNOCK]  = RST_LONG_KNOCK;
            timing[REG_SHORT_KNOCK] = RST_SHORT_KNOCK;
            timing[REG_SETUP]       = RST_SETUP;
            timing[REG_PULSE]       = RST_PULSE;
            timing[REG_HOLD]        = RST_HOLD;
            timing[REG_RECOVER]     = RST_RECOVER;
            timing[REG_POLL_PULSE]  = RST_POLL_PULSE;
            ph        = PH_IDLE;
            cnt       = '0;
            pend_byte = '0;
            pend_rs   = 1'b0;
            step      = '0;
            initd     = 1'b0;
            pin_levels_q.delete();
            errs      = 0;
            fail_count <= 0;
            pending    <= 0;
            seq_idle   <= 1'b1;
        end
        else
        begin
            if (cfg.valid && cfg.ready && cfg.index < NUM_REGS)
                timing[cfg.index] = cfg.data;

            if (res.valid && res.ready)
            begin
                got.lcd_enable = res.lcd_enable;
                got.lcd_rs     = res.lcd_rs;
                got.lcd_rw     = res.lcd_rw;
                got.bus_out    = res.bus_out;
                got.bus_drive  = res.bus_drive;
                got.ready_res  = res.ready_res;
                got.rejected   = res.rejected;
                if (pin_levels_q.size() == 0)
                begin
                    $display("%0d ns: result with nothing expected, expected none, actual %h",
                             $time, got);
                    errs++;
                end
                else
                begin
                    want = pin_levels_q.pop_front();
                    check_field("lcd_enable", 8'(want.lcd_enable), 8'(got.lcd_enable));
                    check_field("lcd_rs", 8'(want.lcd_rs), 8'(got.lcd_rs));
                    check_field("lcd_rw", 8'(want.lcd_rw), 8'(got.lcd_rw));
                    check_field("bus_out", want.bus_out, got.bus_out);
                    check_field("bus_drive", 8'(want.bus_drive), 8'(got.bus_drive));
                    check_field("ready_res", 8'(want.ready_res), 8'(got.ready_res));
                    check_field("rejected", 8'(want.rejected), 8'(got.rejected));
                end
            end

            if (req.valid && req.ready)
            begin
                tick_sequencer(req.mode, req.value, req.col, req.row, req.bus_in, want);
                pin_levels_q.push_back(want);
            end

            fail_count <= errs;
            pending    <= pin_levels_q.size();
            seq_idle   <= (ph == PH_IDLE);
        end
    end

endmodule

/* tb/sv/tb_char_lcd_bus_sequencer_unit.sv */
// Testbench top for the LCD bus sequencer: reset, clock, item and register stimulus, verdict.
`timescale 1ns / 1ps

module tb_char_lcd_bus_sequencer_unit;
    import clcd_pkg::*;

    logic clk = 1'b0;
    logic rst_n;
    logic quiet = 1'b0;     // no idling on either side once set
    int   gap_odds = 4;
    int   fail_count;
    int   pending;
    logic seq_idle;

    clcd_req_if req_ch ();
    clcd_res_if res_ch ();
    clcd_cfg_if cfg_ch ();

    char_lcd_bus_sequencer_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    clcd_pin_checker pin_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .res        (res_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .seq_idle   (seq_idle)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hand over one item, with an occasional gap in front of it
    task automatic send_item(input logic [2:0] m, input logic [7:0] v, input logic [7:0] c,
                             input logic [7:0] r, input logic [7:0] b);
        if ($urandom_range(0, 149) == 0)
            gap_odds = $urandom_range(0, 2) * 4;
        if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.mode   <= m;
        req_ch.value  <= v;
        req_ch.col    <= c;
        req_ch.row    <= r;
        req_ch.bus_in <= b;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Plain ticks with the busy flag clear until the sequencer is back to idle
    task automatic settle_idle();
        do
        begin
            send_item(MODE_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom_range(0, 127)));
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        while (!seq_idle);
    endtask

    task automatic drain_results();
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Every timing register drawn from lo..hi, plus one write past the last register
    task automatic program_timing(input int unsigned lo, input int unsigned hi);
        logic [CFG_IDX_W-1:0] spare;
        for (int i = 0; i < NUM_REGS; i++)
            write_reg(CFG_IDX_W'(i), REG_W'($urandom_range(hi, lo)));
        spare = CFG_IDX_W'(NUM_REGS + $urandom_range(0, (1 << CFG_IDX_W) - 1 - NUM_REGS));
        write_reg(spare, REG_W'($urandom));
    endtask

    // One request from idle, followed by a poll that finds the panel busy
    task automatic transfer(input logic [2:0] m, input logic [7:0] v, input logic [7:0] c,
                            input logic [7:0] r);
        settle_idle();
        send_item(m, v, c, r, 8'h00);
        send_item(MODE_TICK, 8'h00, 8'h00, 8'h00, 8'h80);
    endtask

    // Result side: ready dropped in random bursts, with quiet stretches
    initial
    begin
        int odds;
        odds = 10;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 149) == 0)
                odds = $urandom_range(0, 2) * 10;
            if (!quiet && odds != 0 && $urandom_range(1, odds) == 1)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
        end
    end

    // Stimulus and verdict
    initial
    begin
        logic [7:0] bi;
        logic [2:0] m;
        int         pick;
        rst_n         <= 1'b0;
        req_ch.valid  <= 1'b0;
        req_ch.mode   <= MODE_TICK;
        req_ch.value  <= '0;
        req_ch.col    <= '0;
        req_ch.row    <= '0;
        req_ch.bus_in <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= REG_BOOT;
        cfg_ch.data   <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero timing: every phase clamps to a single tick
        program_timing(0, 0);

        // requests before the power-up sequence are dropped
        send_item(MODE_INSTR, 8'hA5, 8'h00, 8'h00, 8'h00);
        send_item(MODE_DATA, 8'h5A, 8'h00, 8'h00, 8'h00);
        send_item(MODE_POS, 8'h00, 8'h05, 8'h01, 8'h00);
        // unused modes act as ticks
        send_item(MODE_INIT + 3'd1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_item(MODE_INIT + 3'd2, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(MODE_INIT + 3'd3, 8'hFF, 8'hFF, 8'hFF, 8'h7F);
        send_item(MODE_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        // power-up, with requests landing while it runs
        send_item(MODE_INIT, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(MODE_INSTR, 8'h01, 8'h00, 8'h00, 8'h80);
        send_item(MODE_INIT, 8'h00, 8'h00, 8'h00, 8'hFF);

        // extreme bytes and positions, each with a repeated poll
        transfer(MODE_INSTR, 8'h00, 8'h00, 8'h00);
        transfer(MODE_INSTR, 8'hFF, 8'h00, 8'h00);
        transfer(MODE_DATA, 8'h00, 8'h00, 8'h00);
        transfer(MODE_DATA, 8'hFF, 8'h00, 8'h00);
        transfer(MODE_POS, 8'h00, 8'd0, 8'd0);
        transfer(MODE_POS, 8'h00, 8'd255, 8'd255);
        transfer(MODE_POS, 8'h00, 8'd19, 8'd1);
        transfer(MODE_POS, 8'h00, 8'd20, 8'd2);
        transfer(MODE_POS, 8'hFF, 8'd39, 8'd3);
        // a request in the very item that ends the transfer is dropped
        repeat (6) send_item(MODE_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(MODE_DATA, 8'h77, 8'h00, 8'h00, 8'h00);
        // re-init from idle
        settle_idle();
        send_item(MODE_INIT, 8'h00, 8'h00, 8'h00, 8'h00);

        // random traffic under several timing settings
        for (int seg = 0; seg < 4; seg++)
        begin
            settle_idle();
            drain_results();
            case (seg)
                0: program_timing(1, 1);
                1: program_timing(0, 6);
                2: program_timing(2, 12);
                default:
                begin
                    quiet <= 1'b1;
                    program_timing(0, 4);
                end
            endcase
            for (int n = 0; n < 350; n++)
            begin
                pick  = $urandom_range(0, 99);
                bi    = 8'($urandom);
                bi[7] = ($urandom_range(0, 2) == 0);
                if (pick < 55)
                    m = MODE_TICK;
                else if (pick < 85)
                    m = MODE_INSTR + 3'($urandom_range(0, 2));
                else if (pick < 95)
                    m = MODE_INIT + 3'($urandom_range(1, 3));
                else if (pick < 97)
                    m = MODE_INIT;
                else
                    m = MODE_TICK;
                send_item(m, 8'($urandom), 8'($urandom), 8'($urandom), bi);
            end
        end

        // leave the largest setting in place on an idle block
        settle_idle();
        drain_results();
        program_timing((1 << REG_W) - 1, (1 << REG_W) - 1);
        drain_results();
        repeat (10) @(posedge clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
hdl/clcd_pkg.sv
hdl/clcd_ifs.sv
hdl/clcd_cfg_regs.sv
hdl/clcd_core.sv
hdl/clcd_out_queue.sv
hdl/char_lcd_bus_sequencer_unit.sv
tb/sv/clcd_pin_checker.sv
tb/sv/tb_char_lcd_bus_sequencer_unit.sv
